>>> rtl/core/os_pkg.sv
// Package for the order statistic set: shared constants, command and status
// codes, controller states and the per-cell control bundle.
// Depends on nothing; every other file of the block uses it.
package os_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int KEY_BITS_DEF = 32;
  localparam int RANK_W       = 10;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_REMOVE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_DUP  = 2'd1,
    ST_FULL = 2'd2,
    ST_RANK = 2'd3
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EVAL = 1'b1
  } state_t;

  // Broadcast to every cell of the chain.
  typedef struct packed {
    logic capture;  // register compare flags against the broadcast key and rank
    logic insert;   // open a slot at the insert point, shifting toward the tail
    logic remove;   // close the slot at the rank, shifting toward the head
  } cell_ctl_t;

endpackage

>>> rtl/core/os_in_if.sv
// Input channel of the order statistic set: valid/ready and the command payload.
// Depends on os_pkg for the rank width.
interface os_in_if #(
  parameter int KEY_W = os_pkg::KEY_BITS_DEF
);
  logic                        valid;
  logic                        ready;
  logic                        command;
  logic signed [KEY_W-1:0]     key;
  logic [os_pkg::RANK_W-1:0]   rank;

  modport source (output valid, command, key, rank, input ready);
  modport sink   (input valid, command, key, rank, output ready);
endinterface

>>> rtl/core/os_out_if.sv
// Result channel of the order statistic set: valid/ready and the result payload.
// Depends on os_pkg for default widths.
interface os_out_if #(
  parameter int KEY_W = os_pkg::KEY_BITS_DEF,
  parameter int CNT_W = $clog2(os_pkg::CAPACITY_DEF + 1)
);
  logic                    valid;
  logic                    ready;
  logic [CNT_W-1:0]        count_at_or_above;
  logic signed [KEY_W-1:0] removed_key;
  logic [1:0]              status;

  modport source (output valid, count_at_or_above, removed_key, status, input ready);
  modport sink   (input valid, count_at_or_above, removed_key, status, output ready);
endinterface

>>> rtl/core/os_cell.sv
// One slot of the sorted key chain: holds a key, compares it with the broadcast
// key and rank, and takes a neighbor's key when the chain shifts. Uses os_pkg.
module os_cell #(
  parameter int KEY_W = os_pkg::KEY_BITS_DEF,
  parameter int IDX_W = os_pkg::RANK_W,
  parameter int IDX   = 0
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  os_pkg::cell_ctl_t         ctl,
  input  logic signed [KEY_W-1:0]   key_in,
  input  logic [os_pkg::RANK_W-1:0] rank_in,
  input  logic [IDX_W:0]            occ_in,
  input  logic signed [KEY_W-1:0]   left_key,
  input  logic                      left_ge,
  input  logic signed [KEY_W-1:0]   right_key,
  output logic signed [KEY_W-1:0]   key_r,
  output logic                      ge_r,
  output logic                      eq_r,
  output logic                      rsel_r
);
  import os_pkg::*;

  localparam logic [IDX_W:0] MY_IDX = (IDX_W + 1)'(IDX);

  logic                    live;
  logic [IDX_W:0]          rank_ext;
  logic                    rge_r;
  logic signed [KEY_W-1:0] key_nxt;

  // Only slots below the occupancy hold a meaningful key.
  assign live     = MY_IDX < occ_in;
  assign rank_ext = (IDX_W + 1)'(rank_in);

  always_comb begin
    key_nxt = key_r;
    if (ctl.insert && !ge_r) begin
      key_nxt = left_ge ? key_in : left_key;
    end else if (ctl.remove && rge_r) begin
      key_nxt = right_key;
    end
  end

  always_ff @(posedge clk) begin
    key_r <= key_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ge_r   <= 1'b0;
      eq_r   <= 1'b0;
      rsel_r <= 1'b0;
      rge_r  <= 1'b0;
    end else if (ctl.capture) begin
      ge_r   <= live && (key_r >= key_in);
      eq_r   <= live && (key_r == key_in);
      rsel_r <= MY_IDX == rank_ext;
      rge_r  <= MY_IDX >= rank_ext;
    end
  end

endmodule

>>> rtl/core/order_statistic_set.sv
// Top level of the order statistic set: the chain of key cells, the count and
// select encoders, the two-state controller and the result register.
// Depends on os_pkg, os_in_if, os_out_if and os_cell.
//
// The block keeps up to CAPACITY distinct signed keys in descending order, one
// key per cell of a chain. In the accept cycle of a transaction the key and
// rank are broadcast to all cells, which register their compare flags; then,
// in the evaluate state, those flags are encoded into the count of keys at
// or above the new key (or into the removed key), and once the result
// register is free the chain shifts one place right for an insert or left for
// a remove, so the set is up to date for the transaction that follows. A new
// transaction is accepted only after the previous one has left the evaluate
// state. A result waits in an output register; a new transaction is accepted
// while it waits, and only the evaluate state of that next transaction stalls
// until the result has been taken. There is no clearing pass after reset: the
// occupancy count, cleared by reset, marks which cells hold keys. Inserting a
// key already present reports status duplicate and leaves the set unchanged,
// an insert into a full set reports full and drops the key, and removing at a
// rank at or beyond the occupancy reports rank out of range with a removed
// key of zero. Removes report a count of zero and inserts a removed key of
// zero.
module order_statistic_set #(
  parameter int CAPACITY = os_pkg::CAPACITY_DEF,
  parameter int KEY_BITS = os_pkg::KEY_BITS_DEF
) (
  input logic      clk,
  input logic      rst_n,
  os_in_if.sink    in_ch,
  os_out_if.source out_ch
);
  import os_pkg::*;

  localparam int CAP_LOG = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int IDX_W   = (CAP_LOG > RANK_W) ? CAP_LOG : RANK_W;
  localparam int CNT_W   = $clog2(CAPACITY + 1);

  state_t                   state_r, state_nxt;
  cell_ctl_t                ctl;
  logic                     accept;
  logic                     commit;

  logic                     cmd_r;
  logic signed [KEY_BITS-1:0] key_hold_r;
  logic [RANK_W-1:0]        rank_hold_r;
  logic [CNT_W-1:0]         occ_r, occ_nxt;

  logic signed [KEY_BITS-1:0] key_bc;
  logic [RANK_W-1:0]        rank_bc;

  logic signed [KEY_BITS-1:0] key_a [CAPACITY];
  logic [CAPACITY-1:0]      ge_v;
  logic [CAPACITY-1:0]      eq_v;
  logic [CAPACITY-1:0]      rsel_v;

  logic [CNT_W-1:0]         cnt_enc;
  logic signed [KEY_BITS-1:0] sel_key;
  logic                     dup;
  logic                     full;
  logic                     rank_bad;
  logic                     do_insert;
  logic                     do_remove;

  logic                     out_valid_r;
  logic [CNT_W-1:0]         out_cnt_r;
  logic signed [KEY_BITS-1:0] out_key_r;
  status_t                  out_status_r;
  status_t                  status_nxt;

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  // The result register is free when empty or being drained this cycle.
  assign commit      = (state_r == S_EVAL) && (!out_valid_r || out_ch.ready);

  // The compare cycle sees the incoming key; the shift cycle loads the held one.
  assign key_bc  = (state_r == S_IDLE) ? in_ch.key : key_hold_r;
  assign rank_bc = (state_r == S_IDLE) ? in_ch.rank : rank_hold_r;

  // The chain of cells. Cell zero always sees the insert point on its left.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [KEY_BITS-1:0] lkey;
    logic                       lge;
    logic signed [KEY_BITS-1:0] rkey;

    if (g == 0) begin : g_head
      assign lkey = key_bc;
      assign lge  = 1'b1;
    end else begin : g_mid
      assign lkey = key_a[g-1];
      assign lge  = ge_v[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign rkey = '0;
    end else begin : g_body
      assign rkey = key_a[g+1];
    end

    os_cell #(
      .KEY_W (KEY_BITS),
      .IDX_W (IDX_W),
      .IDX   (g)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl       (ctl),
      .key_in    (key_bc),
      .rank_in   (rank_bc),
      .occ_in    ((IDX_W + 1)'(occ_r)),
      .left_key  (lkey),
      .left_ge   (lge),
      .right_key (rkey),
      .key_r     (key_a[g]),
      .ge_r      (ge_v[g]),
      .eq_r      (eq_v[g]),
      .rsel_r    (rsel_v[g])
    );
  end

  // The cells at or above the key form a prefix of the chain, so the count is
  // the position of its last cell plus one, found by OR-ing one-hot positions.
  always_comb begin
    cnt_enc = '0;
    sel_key = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (ge_v[i] && ((i == CAPACITY - 1) || !ge_v[(i + 1) % CAPACITY])) begin
        cnt_enc = cnt_enc | CNT_W'(i + 1);
      end
      if (rsel_v[i]) begin
        sel_key = sel_key | key_a[i];
      end
    end
  end

  // Keys are distinct, so any equal live cell is the one just above the insert point.
  assign dup      = |eq_v;
  assign full     = occ_r == CNT_W'(CAPACITY);
  assign rank_bad = (IDX_W + 1)'(rank_hold_r) >= (IDX_W + 1)'(occ_r);

  always_comb begin
    do_insert  = 1'b0;
    do_remove  = 1'b0;
    status_nxt = ST_OK;
    if (cmd_r == CMD_INSERT) begin
      if (dup) begin
        status_nxt = ST_DUP;
      end else if (full) begin
        status_nxt = ST_FULL;
      end else begin
        do_insert = 1'b1;
      end
    end else begin
      if (rank_bad) begin
        status_nxt = ST_RANK;
      end else begin
        do_remove = 1'b1;
      end
    end
  end

  // Controller: compare cycle in IDLE on accept, encode and shift in EVAL.
  always_comb begin
    state_nxt   = state_r;
    ctl.capture = 1'b0;
    ctl.insert  = 1'b0;
    ctl.remove  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        ctl.capture = accept;
        if (accept) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        ctl.insert = commit && do_insert;
        ctl.remove = commit && do_remove;
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    occ_nxt = occ_r;
    if (ctl.insert) begin
      occ_nxt = occ_r + CNT_W'(1);
    end else if (ctl.remove) begin
      occ_nxt = occ_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      occ_r   <= occ_nxt;
      if (commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= in_ch.command;
      key_hold_r  <= in_ch.key;
      rank_hold_r <= in_ch.rank;
    end
    if (commit) begin
      out_cnt_r    <= (cmd_r == CMD_INSERT) ? cnt_enc : '0;
      out_key_r    <= do_remove ? sel_key : '0;
      out_status_r <= status_nxt;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.count_at_or_above = out_cnt_r;
  assign out_ch.removed_key       = out_key_r;
  assign out_ch.status            = out_status_r;

`ifndef NO_ASSERTIONS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= CNT_W'(CAPACITY))
    else $error("occupancy beyond capacity");

  a_eq_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> $onehot0(eq_v))
    else $error("stored keys are not distinct");

  a_rsel_unique: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> $onehot0(rsel_v))
    else $error("more than one cell selected for removal");

  a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.insert |=> occ_r == $past(occ_r) + CNT_W'(1))
    else $error("insert did not grow the set");

  a_no_lost_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL && out_valid_r && !out_ch.ready) |=> out_valid_r)
    else $error("pending result dropped");
`endif

endmodule
